### design/per_user_token_bucket_limiter_unit_defines.svh
// Assertion macros shared by the token bucket limiter RTL.
// Used by per_user_token_bucket_limiter_unit.sv; relies on aclk and aresetn in scope.
`ifndef PER_USER_TOKEN_BUCKET_LIMITER_UNIT_DEFINES_SVH
`define PER_USER_TOKEN_BUCKET_LIMITER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTBL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptbl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PTBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptbl assertion failed");

`endif

### design/ptbl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the per-user token bucket limiter.
// No dependencies; imported by the limiter top level.
package ptbl_pkg;

    localparam int unsigned CFG_W       = 12;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned SLOT_W      = 8;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned TOKEN_W     = 24;
    localparam int unsigned REFILL_W    = TIME_W + CFG_W;
    localparam int unsigned ENTRY_W     = TOKEN_W + TIME_W;
    localparam int unsigned MAX_ENTRIES = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREMIUM_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_WINDOW = 2'd2;

    localparam logic [CFG_W-1:0] FREE_LIMIT_RST    = 12'd5;
    localparam logic [CFG_W-1:0] PREMIUM_LIMIT_RST = 12'd100;
    localparam logic [CFG_W-1:0] WINDOW_RST        = 12'd60;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_FIN
    } ptbl_state_t;

endpackage

### design/per_user_token_bucket_limiter_unit.sv
`timescale 1ns / 1ps
// Per-user token bucket limiter: top level with bucket table and refill datapath.
// Depends on ptbl_pkg, ptbl_ram and per_user_token_bucket_limiter_unit_defines.svh.
//
// Usage:
// Requests arrive on the s_ channel (slot, tier, time in seconds) and every
// request yields exactly one decision on the m_ channel (allowed flag and
// tokens left in 1/window units). Register writes through cfg_wr_en,
// cfg_index and cfg_data take effect at once and are meant for idle periods.
// One request is in work at a time: the bucket entry is read from the table
// RAM at the accepting edge, the refill products are formed in the next
// cycle, the sum is clamped in the one after, and the decision is written
// back and registered on the output in ST_FIN. A new request is taken only
// after ST_FIN has handed its decision to the output register, so requests
// do not overlap across the RAM read and the two multiply and add stages. If
// the receiver stalls with a result still held, the final stage waits until
// the output register frees, then the block goes on.
// Reset clears all bucket valid flags (so every slot starts full) and
// restores the register defaults; no clearing pass over the RAM is needed.
`include "per_user_token_bucket_limiter_unit_defines.svh"

module per_user_token_bucket_limiter_unit
    import ptbl_pkg::*;
#(
    parameter int unsigned USER_SLOTS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // [7:0] user_slot, [39:8] now_seconds
    input  logic                 s_tuser,   // [0] premium
    // Decision channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [0] allowed, [24:1] tokens_left_scaled
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned DEPTH  = (USER_SLOTS > MAX_ENTRIES) ? MAX_ENTRIES : USER_SLOTS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ptbl_state_t state_reg, state_next;

    logic [CFG_W-1:0]    free_limit_reg, premium_limit_reg, window_cfg_reg;

    logic [DEPTH-1:0]    valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                premium_reg, in_range_reg, hit_reg;
    logic [TIME_W-1:0]   now_reg;

    logic [TOKEN_W-1:0]  tokens_reg, cap_reg, clamp_reg;
    logic [CFG_W-1:0]    window_reg;
    logic [REFILL_W-1:0] refill_reg;

    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;

    logic                accept, fin_go;
    logic [SLOT_W-1:0]   in_slot;
    logic                in_range;
    logic [ADDR_W-1:0]   in_addr;

    logic [ENTRY_W-1:0]  ram_rdata, ram_wdata;
    logic                ram_we;

    logic [CFG_W-1:0]    limit, window_eff;
    logic [TOKEN_W-1:0]  cap_w;
    logic [TIME_W-1:0]   elapsed;
    logic [REFILL_W-1:0] refill_w;
    logic [REFILL_W:0]   sum_w;
    logic [TOKEN_W-1:0]  clamp_w, left_w;
    logic                ok_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_range = ({24'd0, in_slot} < 32'(USER_SLOTS));
    assign in_addr  = in_slot[ADDR_W-1:0];
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_limit_reg    <= FREE_LIMIT_RST;
            premium_limit_reg <= PREMIUM_LIMIT_RST;
            window_cfg_reg    <= WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FREE_LIMIT:    free_limit_reg    <= cfg_data;
                CFG_PREMIUM_LIMIT: premium_limit_reg <= cfg_data;
                CFG_REFILL_WINDOW: window_cfg_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bucket table: tokens in the low bits, last refill time above them.
    ptbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(in_addr),
        .rdata(ram_rdata)
    );

    // Refill products, formed while the table data is fresh.
    always_comb begin
        limit      = premium_reg ? premium_limit_reg : free_limit_reg;
        window_eff = (window_cfg_reg == '0) ? CFG_W'(1) : window_cfg_reg;
        cap_w      = TOKEN_W'(limit) * TOKEN_W'(window_eff);
        elapsed    = hit_reg ? (now_reg - ram_rdata[ENTRY_W-1:TOKEN_W]) : '0;
        refill_w   = REFILL_W'(elapsed) * REFILL_W'(limit);
    end

    always_comb begin
        sum_w   = (REFILL_W+1)'(tokens_reg) + (REFILL_W+1)'(refill_reg);
        clamp_w = (sum_w > (REFILL_W+1)'(cap_reg)) ? cap_reg : sum_w[TOKEN_W-1:0];
        ok_w    = (clamp_reg >= TOKEN_W'(window_reg));
        left_w  = ok_w ? (clamp_reg - TOKEN_W'(window_reg)) : clamp_reg;
    end

    assign ram_we    = fin_go && in_range_reg;
    assign ram_wdata = {now_reg, left_w};

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg     <= in_addr;
            premium_reg  <= s_tuser;
            now_reg      <= s_tdata[39:8];
            in_range_reg <= in_range;
            hit_reg      <= in_range && valid_reg[in_addr];
        end
        if (state_reg == ST_MUL) begin
            cap_reg    <= cap_w;
            window_reg <= window_eff;
            tokens_reg <= hit_reg ? ram_rdata[TOKEN_W-1:0] : cap_w;
            refill_reg <= refill_w;
        end
        if (state_reg == ST_SUM) begin
            clamp_reg <= clamp_w;
        end
        if (fin_go) begin
            m_tdata_reg <= in_range_reg ? {7'd0, left_w, ok_w} : '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    `PTBL_ASSERT_NEXT(a_accept_busy, accept, !s_tready)
    `PTBL_ASSERT_NOW(a_clamp_bound, state_reg == ST_FIN, clamp_reg <= cap_reg)
    `PTBL_ASSERT_NEXT(a_fin_output, fin_go, m_tvalid)
    `PTBL_ASSERT_NEXT(a_range_block, fin_go && !in_range_reg, m_tdata == 32'd0)

endmodule

### design/ptbl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ptbl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
